// ----- design/axis_rotate_translate_3d_core_defines.svh -----
// ----------------------------------------------------------------------------
// axis_rotate_translate_3d_core_defines.svh
// Assertion macros shared by the rotate/translate core.
// ----------------------------------------------------------------------------
`ifndef AXIS_ROTATE_TRANSLATE_3D_CORE_DEFINES_SVH
`define AXIS_ROTATE_TRANSLATE_3D_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define ARTR3D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ARTR3D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always active (for reset behavior)
`define ARTR3D_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/artr3d_pkg.sv -----
// ----------------------------------------------------------------------------
// artr3d_pkg
// Types and constants of the 3D axis rotation / translation core.
// ----------------------------------------------------------------------------
package artr3d_pkg;

    localparam int COORD_W  = 32;   // Q16.16 coordinates
    localparam int ANG_W    = 16;   // angle, 1/64 degree
    localparam int AXIS_W   = 2;
    localparam int CW       = 34;   // CORDIC x/y, Q2.30 with headroom
    localparam int ZW       = 32;   // CORDIC angle, 2^-24 degree
    localparam int TRIG_W   = 16;   // sin/cos, Q1.15
    localparam int FRAC     = 15;
    localparam int PROD_W   = TRIG_W + COORD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int RED_W    = ANG_W + 1;
    localparam int ANG_SHIFT = 18;

    localparam int TURN         = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;
    localparam int CORDIC_GAIN  = 652032875;
    localparam int ATAN_N       = 24;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

    // atan(2^-i) in units of 2^-24 degree
    localparam logic signed [ZW-1:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic [AXIS_W-1:0]         axis;
        logic                      flip;
    } t_pass;

endpackage

// ----- design/artr3d_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// artr3d_cordic_cell
// One rotation-mode CORDIC iteration; carries the point payload alongside.
// ----------------------------------------------------------------------------
module artr3d_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  artr3d_pkg::t_rot  i_rot,
    input  artr3d_pkg::t_pass i_pass,
    output logic              o_valid,
    output artr3d_pkg::t_rot  o_rot,
    output artr3d_pkg::t_pass o_pass
);
    import artr3d_pkg::*;

    logic              r_valid;
    t_rot              r_rot;
    t_pass             r_pass;
    t_rot              n_rot;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;

    assign w_dx = i_rot.y >>> STEP;
    assign w_dy = i_rot.x >>> STEP;

    always_comb begin
        if (!i_rot.z[ZW-1]) begin
            n_rot.x = i_rot.x - w_dx;
            n_rot.y = i_rot.y + w_dy;
            n_rot.z = i_rot.z - ATAN_TAB[STEP];
        end else begin
            n_rot.x = i_rot.x + w_dx;
            n_rot.y = i_rot.y - w_dy;
            n_rot.z = i_rot.z + ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot  <= n_rot;
            r_pass <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_pass  = r_pass;

endmodule

// ----- design/artr3d_xform.sv -----
// ----------------------------------------------------------------------------
// artr3d_xform
// Rounds sin/cos, applies the rotation matrix and translation, saturates.
// ----------------------------------------------------------------------------
module artr3d_xform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  artr3d_pkg::t_rot                      i_rot,
    input  artr3d_pkg::t_pass                     i_pass,
    output logic                                  o_valid,
    output logic signed [artr3d_pkg::COORD_W-1:0] o_x,
    output logic signed [artr3d_pkg::COORD_W-1:0] o_y,
    output logic signed [artr3d_pkg::COORD_W-1:0] o_z
);
    import artr3d_pkg::*;

    localparam int Q15_W = CW + 1 - FRAC;
    localparam int OUT_SH_W = ACC_W + 1 - FRAC;

    // 32-bit signed limits, sign-extended to the shifted sum width
    localparam logic signed [OUT_SH_W-1:0] OUT_MAX =
        OUT_SH_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    localparam logic signed [OUT_SH_W-1:0] OUT_MIN =
        OUT_SH_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));

    function automatic logic signed [TRIG_W-1:0] q30_to_q15(input logic signed [CW-1:0] v);
        logic signed [CW:0]      sum;
        logic signed [Q15_W-1:0] shr;
        logic signed [TRIG_W-1:0] res;
        sum = (CW+1)'(v) + (CW+1)'(1 <<< (FRAC - 1));
        shr = Q15_W'(sum >>> FRAC);
        if (shr > Q15_W'(2 ** (TRIG_W - 1) - 1)) begin
            res = {1'b0, {(TRIG_W-1){1'b1}}};
        end else if (shr < -Q15_W'(2 ** (TRIG_W - 1))) begin
            res = {1'b1, {(TRIG_W-1){1'b0}}};
        end else begin
            res = TRIG_W'(shr);
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0]      sum;
        logic signed [OUT_SH_W-1:0] shr;
        logic signed [COORD_W-1:0]  res;
        sum = (ACC_W+1)'(v) + (ACC_W+1)'(1 <<< (FRAC - 1));
        shr = OUT_SH_W'(sum >>> FRAC);
        if (shr > OUT_MAX) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (shr < OUT_MIN) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = COORD_W'(shr);
        end
        return res;
    endfunction

    // trig stage
    logic                     r_t_valid;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    t_pass                    r_t_pass;
    logic signed [CW-1:0]     n_cx;
    logic signed [CW-1:0]     n_sy;

    // multiply stage
    logic                      r_m_valid;
    logic signed [PROD_W-1:0]  r_m_cpa;
    logic signed [PROD_W-1:0]  r_m_spb;
    logic signed [PROD_W-1:0]  r_m_spa;
    logic signed [PROD_W-1:0]  r_m_cpb;
    logic signed [COORD_W-1:0] r_m_pc;
    logic signed [COORD_W-1:0] r_m_sx;
    logic signed [COORD_W-1:0] r_m_sy;
    logic signed [COORD_W-1:0] r_m_sz;
    logic [AXIS_W-1:0]         r_m_axis;
    logic signed [COORD_W-1:0] w_pa;
    logic signed [COORD_W-1:0] w_pb;
    logic signed [COORD_W-1:0] w_pc;

    // sum stage
    logic                    r_s_valid;
    logic signed [ACC_W-1:0] r_s_ax;
    logic signed [ACC_W-1:0] r_s_ay;
    logic signed [ACC_W-1:0] r_s_az;
    logic signed [ACC_W-1:0] w_f;
    logic signed [ACC_W-1:0] w_g;
    logic signed [ACC_W-1:0] w_i;
    logic signed [ACC_W-1:0] n_ax;
    logic signed [ACC_W-1:0] n_ay;
    logic signed [ACC_W-1:0] n_az;

    // output register
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic signed [COORD_W-1:0] r_out_z;

    // quadrant fold: negate before rounding
    assign n_cx = i_pass.flip ? -i_rot.x : i_rot.x;
    assign n_sy = i_pass.flip ? -i_rot.y : i_rot.y;

    // (a, b) is the rotated pair, c the coordinate on the axis
    always_comb begin
        case (r_t_pass.axis)
            AXIS_X: begin
                w_pa = r_t_pass.py;
                w_pb = r_t_pass.pz;
                w_pc = r_t_pass.px;
            end
            AXIS_Y: begin
                w_pa = r_t_pass.pz;
                w_pb = r_t_pass.px;
                w_pc = r_t_pass.py;
            end
            default: begin
                w_pa = r_t_pass.px;
                w_pb = r_t_pass.py;
                w_pc = r_t_pass.pz;
            end
        endcase
    end

    assign w_f = ACC_W'(r_m_cpa) - ACC_W'(r_m_spb);
    assign w_g = ACC_W'(r_m_spa) + ACC_W'(r_m_cpb);
    assign w_i = ACC_W'(r_m_pc) <<< FRAC;

    always_comb begin
        case (r_m_axis)
            AXIS_X: begin
                n_ax = w_i;
                n_ay = w_f;
                n_az = w_g;
            end
            AXIS_Y: begin
                n_ax = w_g;
                n_ay = w_i;
                n_az = w_f;
            end
            default: begin
                n_ax = w_f;
                n_ay = w_g;
                n_az = w_i;
            end
        endcase
        n_ax = n_ax + (ACC_W'(r_m_sx) <<< FRAC);
        n_ay = n_ay + (ACC_W'(r_m_sy) <<< FRAC);
        n_az = n_az + (ACC_W'(r_m_sz) <<< FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_t_valid   <= i_valid;
            r_m_valid   <= r_t_valid;
            r_s_valid   <= r_m_valid;
            r_out_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos    <= q30_to_q15(n_cx);
            r_sin    <= q30_to_q15(n_sy);
            r_t_pass <= i_pass;

            r_m_cpa  <= r_cos * w_pa;
            r_m_spb  <= r_sin * w_pb;
            r_m_spa  <= r_sin * w_pa;
            r_m_cpb  <= r_cos * w_pb;
            r_m_pc   <= w_pc;
            r_m_sx   <= r_t_pass.sx;
            r_m_sy   <= r_t_pass.sy;
            r_m_sz   <= r_t_pass.sz;
            r_m_axis <= r_t_pass.axis;

            r_s_ax   <= n_ax;
            r_s_ay   <= n_ay;
            r_s_az   <= n_az;

            r_out_x  <= round_sat(r_s_ax);
            r_out_y  <= round_sat(r_s_ay);
            r_out_z  <= round_sat(r_s_az);
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_out_x;
    assign o_y     = r_out_y;
    assign o_z     = r_out_z;

endmodule

// ----- design/axis_rotate_translate_3d_core.sv -----
// ----------------------------------------------------------------------------
// axis_rotate_translate_3d_core
// Rotates a Q16.16 point about x, y or z and adds a translation.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  input   | in        | i_valid / o_stall   | i_in_x..z, i_angle_deg,
//          |           |                     | i_rot_axis, i_shift_x..z
//  output  | out       | o_valid / i_stall   | o_out_x..z
//
// One transfer per cycle in, one per cycle out while the output is not stalled;
// each transfer passes the angle fold register, the chain of CORDIC cells, then
// the trig rounding, multiply, sum and output stages.
// Synchronous active-low reset clears all stage valid bits.
// A stalled result freezes the whole pipeline; otherwise every stage moves.
// ----------------------------------------------------------------------------
module axis_rotate_translate_3d_core #(
    parameter int TRIG_STAGES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [artr3d_pkg::COORD_W-1:0] i_in_x,
    input  logic signed [artr3d_pkg::COORD_W-1:0] i_in_y,
    input  logic signed [artr3d_pkg::COORD_W-1:0] i_in_z,
    input  logic signed [artr3d_pkg::ANG_W-1:0]   i_angle_deg,
    input  logic [artr3d_pkg::AXIS_W-1:0]         i_rot_axis,
    input  logic signed [artr3d_pkg::COORD_W-1:0] i_shift_x,
    input  logic signed [artr3d_pkg::COORD_W-1:0] i_shift_y,
    input  logic signed [artr3d_pkg::COORD_W-1:0] i_shift_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [artr3d_pkg::COORD_W-1:0] o_out_x,
    output logic signed [artr3d_pkg::COORD_W-1:0] o_out_y,
    output logic signed [artr3d_pkg::COORD_W-1:0] o_out_z
);
    import artr3d_pkg::*;

    `include "axis_rotate_translate_3d_core_defines.svh"

    localparam logic signed [ZW-1:0] Z_TOL = ATAN_TAB[TRIG_STAGES-1] <<< 1;

    logic                   w_adv;
    logic signed [RED_W-1:0] w_a;
    logic signed [RED_W-1:0] w_r0;
    logic signed [RED_W-1:0] w_r1;
    logic signed [RED_W-1:0] n_ang;
    logic                   n_flip;
    t_rot                   n_rot0;
    t_pass                  n_pass0;

    logic                   r_p_valid;
    t_rot                   r_p_rot;
    t_pass                  r_p_pass;

    logic [TRIG_STAGES:0]   w_vld;
    t_rot                   w_rot  [0:TRIG_STAGES];
    t_pass                  w_pass [0:TRIG_STAGES];

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // angle into [-90, 90] degrees, remember the half-turn fold
    always_comb begin
        w_a = RED_W'(i_angle_deg);
        if (w_a < -TURN) begin
            w_r0 = RED_W'(w_a + 2 * TURN);
        end else if (w_a < 0) begin
            w_r0 = RED_W'(w_a + TURN);
        end else if (w_a >= TURN) begin
            w_r0 = RED_W'(w_a - TURN);
        end else begin
            w_r0 = w_a;
        end
        w_r1 = (w_r0 >= HALF_TURN) ? RED_W'(w_r0 - TURN) : w_r0;
        if (w_r1 > QUARTER_TURN) begin
            n_ang  = RED_W'(w_r1 - HALF_TURN);
            n_flip = 1'b1;
        end else if (w_r1 < -QUARTER_TURN) begin
            n_ang  = RED_W'(w_r1 + HALF_TURN);
            n_flip = 1'b1;
        end else begin
            n_ang  = w_r1;
            n_flip = 1'b0;
        end
    end

    always_comb begin
        n_rot0.x = CW'(CORDIC_GAIN);
        n_rot0.y = '0;
        n_rot0.z = ZW'(n_ang) <<< ANG_SHIFT;
        n_pass0.px   = i_in_x;
        n_pass0.py   = i_in_y;
        n_pass0.pz   = i_in_z;
        n_pass0.sx   = i_shift_x;
        n_pass0.sy   = i_shift_y;
        n_pass0.sz   = i_shift_z;
        n_pass0.axis = i_rot_axis;
        n_pass0.flip = n_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_adv) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_rot  <= n_rot0;
            r_p_pass <= n_pass0;
        end
    end

    assign w_vld[0]  = r_p_valid;
    assign w_rot[0]  = r_p_rot;
    assign w_pass[0] = r_p_pass;

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        artr3d_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_vld[g]),
            .i_rot   (w_rot[g]),
            .i_pass  (w_pass[g]),
            .o_valid (w_vld[g+1]),
            .o_rot   (w_rot[g+1]),
            .o_pass  (w_pass[g+1])
        );
    end

    artr3d_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_vld[TRIG_STAGES]),
        .i_rot   (w_rot[TRIG_STAGES]),
        .i_pass  (w_pass[TRIG_STAGES]),
        .o_valid (o_valid),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z)
    );

    `ARTR3D_ASSERT_NXT_ALWAYS(a_rst_clears, i_clk, !i_rst_n, !o_valid, "output valid after reset")
    `ARTR3D_ASSERT_NXT(a_freeze, i_clk, i_rst_n, !w_adv, $stable(w_vld), "cell chain moved while frozen")
    `ARTR3D_ASSERT_IMP(a_converge, i_clk, i_rst_n, w_vld[TRIG_STAGES], (w_rot[TRIG_STAGES].z <= Z_TOL) && (w_rot[TRIG_STAGES].z >= -Z_TOL), "CORDIC residual angle out of range")

endmodule
